// ----- rtl/plp_pkg.sv -----
// shared types, character codes and result codes for the partition line parser
package plp_pkg;

    typedef enum logic [3:0] {
        PH_LEAD,
        PH_MODEL,
        PH_BEFORE_COMMA,
        PH_AFTER_COMMA,
        PH_PNAME,
        PH_BEFORE_EQ,
        PH_AFTER_EQ,
        PH_RANGE_START,
        PH_BEGIN,
        PH_BEFORE_DASH,
        PH_AFTER_DASH,
        PH_END,
        PH_TRAIL,
        PH_DONE
    } phase_t;

    localparam logic [2:0] KIND_MODEL_CHAR = 3'd0;
    localparam logic [2:0] KIND_PNAME_CHAR = 3'd1;
    localparam logic [2:0] KIND_RANGE      = 3'd2;
    localparam logic [2:0] KIND_ACCEPT     = 3'd3;
    localparam logic [2:0] KIND_ERROR      = 3'd4;

    localparam logic [2:0] ERR_NO_COMMA  = 3'd0;
    localparam logic [2:0] ERR_NO_EQUALS = 3'd1;
    localparam logic [2:0] ERR_NO_DASH   = 3'd2;
    localparam logic [2:0] ERR_NO_DIGITS = 3'd3;
    localparam logic [2:0] ERR_END_BELOW = 3'd4;
    localparam logic [2:0] ERR_NO_MODEL  = 3'd5;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd6;

    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_EQUALS     = 8'h3D;
    localparam logic [7:0] CH_DASH       = 8'h2D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  name_char;
        logic [31:0] range_begin;
        logic [31:0] range_end;
        logic [2:0]  error_code;
        logic        last_of_run;
    } result_t;

    // results produced by one accepted beat, oldest in first
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    typedef struct packed {
        logic [2:0] level;
    } queue_status_t;

    function automatic result_t make_result(
        input logic [2:0]  kind,
        input logic [7:0]  chr,
        input logic [31:0] rb,
        input logic [31:0] re,
        input logic [2:0]  err
    );
        result_t r;
        r.kind        = kind;
        r.name_char   = chr;
        r.range_begin = rb;
        r.range_end   = re;
        r.error_code  = err;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

// ----- rtl/plp_core.sv -----
// parser state machine and decimal accumulator, one character per beat
module plp_core #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       ch,
    input  logic             line_end,
    output plp_pkg::push_t   push
);
    import plp_pkg::*;

    localparam int NW = NUMBER_WIDTH;
    localparam int WX = (NUMBER_WIDTH > 32) ? NUMBER_WIDTH : 32;

    phase_t          phase_reg, phase_next, phase_mid;
    logic            model_seen_reg, model_seen_next;
    logic [NW-1:0]   begin_reg, begin_next, begin_mid;
    logic [NW-1:0]   acc_reg, acc_next;
    logic            ovf_reg, ovf_next;

    logic [7:0]      c;
    logic            is_dig, is_sp, is_aln;
    logic [3:0]      digit;
    logic [NW+3:0]   acc_ext, acc_sum;
    logic            sum_ovf;
    logic            close_begin, close_end, end_below;
    logic            pre_fail, pre_range, active;
    logic [2:0]      pre_err;
    logic [WX-1:0]   begin_wide, acc_wide;

    logic            main_valid;
    result_t         main_res, range_res, fail_res;

    // character classes and the number-closing step that precedes the main step
    always_comb
    begin
        c      = line_end ? 8'h00 : ch;
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
        is_sp  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        is_aln = is_dig || ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z))
                 || ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
        digit  = c[3:0];

        // acc*10 + d never exceeds 16*2^NW, so four extra bits catch overflow
        acc_ext = (NW+4)'(acc_reg);
        acc_sum = (acc_ext << 3) + (acc_ext << 1) + (NW+4)'(digit);
        sum_ovf = (acc_sum[NW+3:NW] != 4'd0);

        close_begin = (phase_reg == PH_BEGIN) && !is_dig;
        close_end   = (phase_reg == PH_END) && !is_dig;
        end_below   = acc_reg < begin_reg;

        pre_fail  = 1'b0;
        pre_err   = ERR_OVERFLOW;
        pre_range = 1'b0;
        phase_mid = phase_reg;
        begin_mid = begin_reg;
        if ((close_begin || close_end) && ovf_reg)
        begin
            pre_fail = 1'b1;
        end
        else if (close_end && end_below)
        begin
            pre_fail = 1'b1;
            pre_err  = ERR_END_BELOW;
        end
        else if (close_end)
        begin
            pre_range = 1'b1;
            phase_mid = PH_TRAIL;
        end
        else if (close_begin)
        begin
            begin_mid = acc_reg;
            phase_mid = PH_BEFORE_DASH;
        end
        active = (phase_reg != PH_DONE) && !pre_fail;

        begin_wide = WX'(begin_reg);
        acc_wide   = WX'(acc_reg);
    end

    // next state
    always_comb
    begin
        phase_next      = phase_mid;
        model_seen_next = model_seen_reg;
        begin_next      = begin_mid;
        acc_next        = acc_reg;
        ovf_next        = ovf_reg;

        if (pre_fail)
        begin
            phase_next = PH_DONE;
        end
        else if (active)
        begin
            case (phase_mid)
                PH_LEAD, PH_MODEL, PH_BEFORE_COMMA:
                begin
                    if (phase_mid != PH_BEFORE_COMMA && is_aln)
                    begin
                        model_seen_next = 1'b1;
                        phase_next      = PH_MODEL;
                    end
                    else if (is_sp)
                    begin
                        if (phase_mid == PH_MODEL)
                            phase_next = PH_BEFORE_COMMA;
                    end
                    else if (c == CH_COMMA)
                        phase_next = PH_AFTER_COMMA;
                    else
                        phase_next = PH_DONE;
                end
                PH_AFTER_COMMA, PH_PNAME, PH_BEFORE_EQ:
                begin
                    if (phase_mid != PH_BEFORE_EQ && (is_aln || c == CH_UNDERSCORE))
                        phase_next = PH_PNAME;
                    else if (is_sp)
                    begin
                        if (phase_mid == PH_PNAME)
                            phase_next = PH_BEFORE_EQ;
                    end
                    else if (c == CH_EQUALS)
                        phase_next = PH_AFTER_EQ;
                    else
                        phase_next = PH_DONE;
                end
                PH_AFTER_EQ, PH_RANGE_START, PH_AFTER_DASH:
                begin
                    if (is_sp)
                        phase_next = phase_mid;
                    else if (phase_mid == PH_AFTER_EQ && c == CH_COMMA)
                        phase_next = PH_RANGE_START;
                    else if (is_dig)
                    begin
                        phase_next = (phase_mid == PH_AFTER_DASH) ? PH_END : PH_BEGIN;
                        acc_next   = NW'(digit);
                        ovf_next   = 1'b0;
                    end
                    else
                        phase_next = PH_DONE;
                end
                PH_BEGIN, PH_END:
                begin
                    if (!ovf_reg)
                    begin
                        if (sum_ovf)
                            ovf_next = 1'b1;
                        else
                            acc_next = acc_sum[NW-1:0];
                    end
                end
                PH_BEFORE_DASH:
                begin
                    if (c == CH_DASH)
                        phase_next = PH_AFTER_DASH;
                    else if (!is_sp)
                        phase_next = PH_DONE;
                end
                PH_TRAIL:
                begin
                    if (c == CH_COMMA)
                        phase_next = PH_RANGE_START;
                    else if (!is_sp)
                        phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = phase_mid;
                end
            endcase
        end

        // line end rearms the parser after its character has been handled
        if (line_end)
        begin
            phase_next      = PH_LEAD;
            model_seen_next = 1'b0;
            begin_next      = '0;
            acc_next        = '0;
            ovf_next        = 1'b0;
        end
    end

    // results
    always_comb
    begin
        main_valid = 1'b0;
        main_res   = make_result(KIND_ERROR, 8'h00, 32'd0, 32'd0, ERR_NO_COMMA);
        range_res  = make_result(KIND_RANGE, 8'h00, begin_wide[31:0], acc_wide[31:0],
                                 ERR_NO_COMMA);
        fail_res   = make_result(KIND_ERROR, 8'h00, 32'd0, 32'd0, pre_err);

        if (active)
        begin
            case (phase_mid)
                PH_LEAD, PH_MODEL, PH_BEFORE_COMMA:
                begin
                    if (phase_mid != PH_BEFORE_COMMA && is_aln)
                    begin
                        main_valid = 1'b1;
                        main_res   = make_result(KIND_MODEL_CHAR, c, 32'd0, 32'd0,
                                                 ERR_NO_COMMA);
                    end
                    else if (!is_sp && c != CH_COMMA)
                    begin
                        main_valid = 1'b1;
                        main_res.error_code = ERR_NO_COMMA;
                    end
                end
                PH_AFTER_COMMA, PH_PNAME, PH_BEFORE_EQ:
                begin
                    if (phase_mid != PH_BEFORE_EQ && (is_aln || c == CH_UNDERSCORE))
                    begin
                        main_valid = 1'b1;
                        main_res   = make_result(KIND_PNAME_CHAR, c, 32'd0, 32'd0,
                                                 ERR_NO_COMMA);
                    end
                    else if (!is_sp && c != CH_EQUALS)
                    begin
                        main_valid = 1'b1;
                        main_res.error_code = ERR_NO_EQUALS;
                    end
                end
                PH_AFTER_EQ, PH_RANGE_START, PH_AFTER_DASH:
                begin
                    if (!is_sp && !is_dig && !(phase_mid == PH_AFTER_EQ && c == CH_COMMA))
                    begin
                        main_valid = 1'b1;
                        main_res.error_code = ERR_NO_DIGITS;
                    end
                end
                PH_BEFORE_DASH:
                begin
                    if (!is_sp && c != CH_DASH)
                    begin
                        main_valid = 1'b1;
                        main_res.error_code = ERR_NO_DASH;
                    end
                end
                PH_TRAIL:
                begin
                    if (!is_sp && c != CH_COMMA)
                    begin
                        main_valid = 1'b1;
                        if (model_seen_reg)
                            main_res.kind = KIND_ACCEPT;
                        else
                            main_res.error_code = ERR_NO_MODEL;
                    end
                end
                default:
                begin
                    main_valid = 1'b0;
                end
            endcase
        end

        push.count  = 2'd0;
        push.first  = main_res;
        push.second = main_res;
        if (accept)
        begin
            if (pre_fail)
            begin
                push.count = 2'd1;
                push.first = fail_res;
            end
            else if (pre_range && main_valid)
            begin
                push.count = 2'd2;
                push.first = range_res;
            end
            else if (pre_range)
            begin
                push.count = 2'd1;
                push.first = range_res;
            end
            else if (main_valid)
                push.count = 2'd1;
        end
        push.first.last_of_run  = (push.count == 2'd1);
        push.second.last_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LEAD;
            model_seen_reg <= 1'b0;
            begin_reg      <= '0;
            acc_reg        <= '0;
            ovf_reg        <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            model_seen_reg <= model_seen_next;
            begin_reg      <= begin_next;
            acc_reg        <= acc_next;
            ovf_reg        <= ovf_next;
        end
    end

endmodule

// ----- rtl/plp_queue.sv -----
// four-entry result queue, takes up to two results per beat and gives one
module plp_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  plp_pkg::push_t         push,
    input  logic                   pop,
    output plp_pkg::result_t       head,
    output logic                   head_valid,
    output logic                   room,
    output plp_pkg::queue_status_t status
);
    import plp_pkg::*;

    result_t     entry_reg [4];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  level_reg, level_next;
    logic        do_pop;

    always_comb
    begin
        do_pop      = pop && (level_reg != 3'd0);
        wr_ptr_next = wr_ptr_reg + push.count;
        rd_ptr_next = rd_ptr_reg + 2'(do_pop);
        level_next  = level_reg + 3'(push.count) - 3'(do_pop);
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign head_valid   = (level_reg != 3'd0);
    assign room         = (level_reg <= 3'd2);
    assign status.level = level_reg;

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            entry_reg[wr_ptr_reg + 2'd1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            level_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

// ----- rtl/partition_line_parser.sv -----
// top level of the partition line parser: parser core plus result queue
//
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | ch, line_end
// out     | output    | out_valid / out_ready | kind, name_char, range_begin, range_end,
//         |           |                       | error_code, last_of_run
//
// one character per cycle while in_ready is high; its results land in the queue at that clock
// edge and are popped after older results, one result beat per cycle while out_ready is high
// a beat can cause up to two results; in_ready drops when fewer than two queue slots are free
// rst_n clears the parser to the leading-space phase and empties the queue
module partition_line_parser #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    input  logic        line_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  name_char,
    output logic [31:0] range_begin,
    output logic [31:0] range_end,
    output logic [2:0]  error_code,
    output logic        last_of_run
);
    import plp_pkg::*;

    logic          accept;
    push_t         push;
    result_t       head;
    queue_status_t status;
    logic          room;

    assign in_ready = room;
    assign accept   = in_valid && room;

    plp_core #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .ch       (ch),
        .line_end (line_end),
        .push     (push)
    );

    plp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (out_ready),
        .head       (head),
        .head_valid (out_valid),
        .room       (room),
        .status     (status)
    );

    assign kind        = head.kind;
    assign name_char   = head.name_char;
    assign range_begin = head.range_begin;
    assign range_end   = head.range_end;
    assign error_code  = head.error_code;
    assign last_of_run = head.last_of_run;

`ifndef SYNTH
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.level <= 3'd4)
        else $error("result queue level out of range");

    a_push_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> accept)
        else $error("results pushed without an accepted beat");

    a_pair_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (!push.first.last_of_run && push.second.last_of_run
                                  && push.first.kind == KIND_RANGE))
        else $error("two-result beat misordered or mismarked");

    a_valid_matches_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid == (status.level != 3'd0))
        else $error("out_valid disagrees with queue level");

    a_level_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && push.count == 2'd2 && !(out_valid && out_ready))
        |=> status.level == $past(status.level) + 3'd2)
        else $error("queue level did not grow by two");
`endif

endmodule
